// ===== src/mcp_pkg.sv =====
// Shared types and constants for the multichannel convolution pixel engine.
// Holds beat payload structs, opcode and register codes, walker control structs.
// No dependencies; every other file in src imports this package.
`default_nettype none

package mcp_pkg;

  // Data word and digit-serial multiply geometry
  localparam int WORD_W  = 16;
  localparam int DIGIT_W = 4;
  localparam int DIGITS  = WORD_W / DIGIT_W;

  // Signed window coordinate width (origin may sit left of or above the image)
  localparam int COORD_W = 10;

  // Channel count as carried to the walker (covers up to 511 channels)
  localparam int CHAN_CNT_W = 9;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [1:0] {
    OP_LOAD_IMAGE  = 2'd0,
    OP_LOAD_WEIGHT = 2'd1,
    OP_COMPUTE     = 2'd2
  } mcp_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_CHANNELS = 2'd0,
    REG_FILTER_COUNT    = 2'd1,
    REG_CONV_STRIDE     = 2'd2,
    REG_PAD_WIDTH       = 2'd3
  } mcp_reg_e;

  typedef struct packed {
    logic        [1:0]  opcode;
    logic        [5:0]  load_channel;
    logic        [9:0]  load_position;
    logic signed [15:0] load_value;
    logic        [4:0]  out_row;
    logic        [4:0]  out_col;
    logic        [7:0]  filter_index;
  } mcp_in_t;

  typedef struct packed {
    logic signed [15:0] pixel_sum;
    logic        [4:0]  result_row;
    logic        [4:0]  result_col;
    logic        [7:0]  result_filter;
    logic               out_of_range;
  } mcp_out_t;

  // Walk request from the control FSM to the tap walker
  typedef struct packed {
    logic                        start;
    logic [CHAN_CNT_W-1:0]       chans;
    logic signed [COORD_W-1:0]   y0;
    logic signed [COORD_W-1:0]   x0;
  } mcp_walk_cmd_t;

  // Walker status back to the control FSM
  typedef struct packed {
    logic busy;
    logic issue;
  } mcp_walk_sts_t;

endpackage

`default_nettype wire

// ===== src/mcp_ram.sv =====
// Single-port-write, single-port-read word store with registered read data.
// Depends on mcp_pkg for the word width.
`default_nettype none

module mcp_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [mcp_pkg::WORD_W-1:0] wdata_i,
  input  wire logic                      re_i,
  input  wire logic [AW-1:0]             raddr_i,
  output logic      [mcp_pkg::WORD_W-1:0] rdata_o
);
  import mcp_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/mcp_mac.sv =====
// Digit-serial multiply-accumulate: one 16x4 partial product per cycle,
// wrapped 16-bit running sum. Depends on mcp_pkg.
`default_nettype none

module mcp_mac (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clear_i,
  input  wire logic                       issue_i,
  input  wire logic [mcp_pkg::WORD_W-1:0] img_i,
  input  wire logic [mcp_pkg::WORD_W-1:0] wgt_i,
  output logic                            busy_o,
  output logic      [mcp_pkg::WORD_W-1:0] sum_o
);
  import mcp_pkg::*;

  localparam int CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [CNT_W-1:0] DigitLast = CNT_W'(DIGITS - 1);

  logic                      start_q, start_d;
  logic                      act_q, act_d;
  logic [CNT_W-1:0]          dcnt_q, dcnt_d;
  logic [WORD_W-1:0]         sum_q, sum_d;
  logic [WORD_W-1:0]         a_q, a_d;
  logic [WORD_W-DIGIT_W-1:0] b_q, b_d;
  logic [WORD_W-1:0]         opa;
  logic [DIGIT_W-1:0]        opd;
  logic [WORD_W+DIGIT_W-1:0] prod;
  logic [WORD_W-1:0]         part;

  // Pick operands: fresh words on the first digit, shifted copies after
  always_comb begin
    if (start_q) begin
      opa = img_i;
      opd = wgt_i[DIGIT_W-1:0];
    end else begin
      opa = a_q;
      opd = b_q[DIGIT_W-1:0];
    end
    prod = opa * opd;
    part = prod[WORD_W-1:0];
  end

  // Advance the digit sequence and accumulate
  always_comb begin
    start_d = issue_i;
    act_d   = act_q;
    dcnt_d  = dcnt_q;
    a_d     = a_q;
    b_d     = b_q;
    sum_d   = sum_q;
    if (clear_i) begin
      sum_d = '0;
    end else if (start_q || act_q) begin
      sum_d = sum_q + part;
    end
    if (start_q) begin
      a_d    = opa << DIGIT_W;
      b_d    = wgt_i[WORD_W-1:DIGIT_W];
      act_d  = 1'b1;
      dcnt_d = CNT_W'(1);
    end else if (act_q) begin
      a_d    = a_q << DIGIT_W;
      b_d    = b_q >> DIGIT_W;
      dcnt_d = dcnt_q + CNT_W'(1);
      if (dcnt_q == DigitLast) begin
        act_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
      act_q   <= 1'b0;
      dcnt_q  <= '0;
      sum_q   <= '0;
    end else begin
      start_q <= start_d;
      act_q   <= act_d;
      dcnt_q  <= dcnt_d;
      sum_q   <= sum_d;
    end
  end

  // Operand shift registers
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign busy_o = start_q || act_q;
  assign sum_o  = sum_q;

endmodule

`default_nettype wire

// ===== src/mcp_walker.sv =====
// Tap walker: steps channel, window row and window column, skips border taps,
// and issues store reads spaced for the digit-serial MAC. Depends on mcp_pkg.
`default_nettype none

module mcp_walker #(
  parameter int IMAGE_SIZE = 32,
  parameter int WINDOW     = 5,
  parameter int IMG_AW     = 16,
  parameter int WGT_AW     = 11
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mcp_pkg::mcp_walk_cmd_t cmd_i,
  output mcp_pkg::mcp_walk_sts_t      sts_o,
  output logic [IMG_AW-1:0]          img_addr_o,
  output logic [WGT_AW-1:0]          wgt_addr_o
);
  import mcp_pkg::*;

  localparam int TAP_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int WAIT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int SZ_W   = $clog2(IMAGE_SIZE + 1) + 1;
  localparam int OW     = (IMG_AW > COORD_W + SZ_W) ? IMG_AW : COORD_W + SZ_W;
  localparam logic [TAP_W-1:0]          WinLast  = TAP_W'(WINDOW - 1);
  localparam logic [WAIT_W-1:0]         WaitInit = WAIT_W'(DIGITS - 1);
  localparam logic signed [COORD_W-1:0] ImgLim   = COORD_W'(IMAGE_SIZE);
  localparam logic signed [OW-1:0]      ImgRowS  = OW'(IMAGE_SIZE);
  localparam logic [IMG_AW-1:0]         RowStep  = IMG_AW'(IMAGE_SIZE);
  localparam logic [IMG_AW-1:0]         ChanStep = IMG_AW'(IMAGE_SIZE * IMAGE_SIZE);

  logic                      setup_q, setup_d;
  logic                      walk_q, walk_d;
  logic [WAIT_W-1:0]         wait_q, wait_d;
  logic [CHAN_CNT_W-1:0]     chans_q, chans_d;
  logic [CHAN_CNT_W-1:0]     c_q, c_d;
  logic [TAP_W-1:0]          i_q, i_d;
  logic [TAP_W-1:0]          j_q, j_d;
  logic signed [COORD_W-1:0] y0_q, y0_d;
  logic signed [COORD_W-1:0] x0_q, x0_d;
  logic signed [COORD_W-1:0] yy_q, yy_d;
  logic signed [COORD_W-1:0] xx_q, xx_d;
  logic [IMG_AW-1:0]         corg_q, corg_d;
  logic [IMG_AW-1:0]         row_q, row_d;
  logic [IMG_AW-1:0]         ia_q, ia_d;
  logic [WGT_AW-1:0]         wa_q, wa_d;
  logic signed [OW-1:0]      org_full;
  logic [IMG_AW-1:0]         org;
  logic                      inb;
  logic                      act;
  logic                      issue;
  logic                      last_tap;

  // Window origin address inside channel 0
  always_comb begin
    org_full = OW'(y0_q) * ImgRowS + OW'(x0_q);
    org      = org_full[IMG_AW-1:0];
  end

  // Tap decode: border taps are skipped without waiting, image taps wait for the MAC
  always_comb begin
    inb      = (yy_q >= 0) && (yy_q < ImgLim) && (xx_q >= 0) && (xx_q < ImgLim);
    act      = walk_q && (!inb || (wait_q == '0));
    issue    = act && inb;
    last_tap = (j_q == WinLast) && (i_q == WinLast) &&
               (c_q == chans_q - CHAN_CNT_W'(1));
  end

  // Walk sequencing
  always_comb begin
    setup_d = 1'b0;
    walk_d  = walk_q;
    chans_d = chans_q;
    y0_d    = y0_q;
    x0_d    = x0_q;
    c_d     = c_q;
    i_d     = i_q;
    j_d     = j_q;
    yy_d    = yy_q;
    xx_d    = xx_q;
    corg_d  = corg_q;
    row_d   = row_q;
    ia_d    = ia_q;
    wa_d    = wa_q;
    if (issue) begin
      wait_d = WaitInit;
    end else if (wait_q != '0) begin
      wait_d = wait_q - WAIT_W'(1);
    end else begin
      wait_d = wait_q;
    end

    if (cmd_i.start) begin
      setup_d = 1'b1;
      chans_d = cmd_i.chans;
      y0_d    = cmd_i.y0;
      x0_d    = cmd_i.x0;
      yy_d    = cmd_i.y0;
      xx_d    = cmd_i.x0;
      c_d     = '0;
      i_d     = '0;
      j_d     = '0;
      wa_d    = '0;
      wait_d  = '0;
    end else if (setup_q) begin
      corg_d = org;
      row_d  = org;
      ia_d   = org;
      walk_d = 1'b1;
    end else if (act) begin
      wa_d = wa_q + WGT_AW'(1);
      if (j_q != WinLast) begin
        j_d  = j_q + TAP_W'(1);
        xx_d = xx_q + COORD_W'(1);
        ia_d = ia_q + IMG_AW'(1);
      end else if (i_q != WinLast) begin
        j_d   = '0;
        i_d   = i_q + TAP_W'(1);
        yy_d  = yy_q + COORD_W'(1);
        xx_d  = x0_q;
        row_d = row_q + RowStep;
        ia_d  = row_q + RowStep;
      end else begin
        j_d    = '0;
        i_d    = '0;
        c_d    = c_q + CHAN_CNT_W'(1);
        yy_d   = y0_q;
        xx_d   = x0_q;
        corg_d = corg_q + ChanStep;
        row_d  = corg_q + ChanStep;
        ia_d   = corg_q + ChanStep;
      end
      if (last_tap) begin
        walk_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_q <= 1'b0;
      walk_q  <= 1'b0;
      wait_q  <= '0;
      chans_q <= '0;
      c_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      setup_q <= setup_d;
      walk_q  <= walk_d;
      wait_q  <= wait_d;
      chans_q <= chans_d;
      c_q     <= c_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  // Coordinates and addresses
  always_ff @(posedge clk_i) begin
    y0_q   <= y0_d;
    x0_q   <= x0_d;
    yy_q   <= yy_d;
    xx_q   <= xx_d;
    corg_q <= corg_d;
    row_q  <= row_d;
    ia_q   <= ia_d;
    wa_q   <= wa_d;
  end

  assign sts_o.busy  = setup_q || walk_q;
  assign sts_o.issue = issue;
  assign img_addr_o  = ia_q;
  assign wgt_addr_o  = wa_q;

endmodule

`default_nettype wire

// ===== src/multichannel_conv2d_pixel.sv =====
// Multichannel 2-D convolution engine, one output pixel per compute beat.
// Load beats are accepted without stalling the input. A compute beat stalls the input
// until its result is loaded, the digit-serial MAC setting the pace when every tap lies
// inside the image; border taps step without waiting, mostly under a MAC.
// Flagged or zero-channel requests go straight to the finish state; a stalled result holds
// the input. Reset clears control and config only; stores hold unknown data until loaded.
`default_nettype none

module multichannel_conv2d_pixel #(
  parameter int CHANNELS   = 64,
  parameter int IMAGE_SIZE = 32,
  parameter int WINDOW     = 5,
  parameter int FILTERS    = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire mcp_pkg::mcp_in_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output mcp_pkg::mcp_out_t                  out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mcp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mcp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mcp_pkg::*;

  localparam int PixPerChan  = IMAGE_SIZE * IMAGE_SIZE;
  localparam int TapsPerChan = WINDOW * WINDOW;
  localparam int ImgDepth    = CHANNELS * PixPerChan;
  localparam int WgtDepth    = CHANNELS * TapsPerChan;
  localparam int IMG_AW      = (ImgDepth > 1) ? $clog2(ImgDepth) : 1;
  localparam int WGT_AW      = (WgtDepth > 1) ? $clog2(WgtDepth) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [6:0]                act_ch_q;
  logic [8:0]                filt_cnt_q;
  logic [2:0]                stride_q;
  logic [2:0]                pad_q;
  logic                      out_valid_q, out_valid_d;
  mcp_out_t                  out_q;
  logic                      load_out;
  logic [4:0]                req_row_q;
  logic [4:0]                req_col_q;
  logic [7:0]                req_filt_q;
  logic                      req_oor_q;
  logic                      accept;
  logic                      is_comp;
  logic                      img_we;
  logic                      wgt_we;
  logic [IMG_AW-1:0]         img_wa;
  logic [WGT_AW-1:0]         wgt_wa;
  logic                      oor_d;
  logic [CHAN_CNT_W-1:0]     chans_d;
  logic [7:0]                ry;
  logic [7:0]                rx;
  logic signed [COORD_W-1:0] y0_d;
  logic signed [COORD_W-1:0] x0_d;
  logic                      work;
  mcp_walk_cmd_t             walk_cmd;
  mcp_walk_sts_t             walk_sts;
  logic [IMG_AW-1:0]         img_ra;
  logic [WGT_AW-1:0]         wgt_ra;
  logic [WORD_W-1:0]         img_rd;
  logic [WORD_W-1:0]         wgt_rd;
  logic                      mac_busy;
  logic [WORD_W-1:0]         mac_sum;

  // Input beat decode
  always_comb begin
    accept  = in_valid_i && !in_stall_o;
    is_comp = in_data_i.opcode == OP_COMPUTE;
    img_we  = accept && (in_data_i.opcode == OP_LOAD_IMAGE) &&
              (32'(in_data_i.load_channel) < CHANNELS) &&
              (32'(in_data_i.load_position) < PixPerChan);
    wgt_we  = accept && (in_data_i.opcode == OP_LOAD_WEIGHT) &&
              (32'(in_data_i.load_channel) < CHANNELS) &&
              (32'(in_data_i.load_position) < TapsPerChan);
    img_wa  = IMG_AW'(32'(in_data_i.load_channel) * PixPerChan +
                      32'(in_data_i.load_position));
    wgt_wa  = WGT_AW'(32'(in_data_i.load_channel) * TapsPerChan +
                      32'(in_data_i.load_position));
  end

  // Request set-up: range flag, channel count and window origin
  always_comb begin
    oor_d = (32'(in_data_i.filter_index) >= 32'(filt_cnt_q)) ||
            (32'(in_data_i.filter_index) >= FILTERS);
    if (32'(act_ch_q) > CHANNELS) begin
      chans_d = CHAN_CNT_W'(CHANNELS);
    end else begin
      chans_d = CHAN_CNT_W'(act_ch_q);
    end
    ry   = {3'b000, in_data_i.out_row} * {5'b00000, stride_q};
    rx   = {3'b000, in_data_i.out_col} * {5'b00000, stride_q};
    y0_d = COORD_W'(ry) - COORD_W'(pad_q);
    x0_d = COORD_W'(rx) - COORD_W'(pad_q);
    work = !oor_d && (chans_d != '0);
    walk_cmd.start = accept && is_comp && work;
    walk_cmd.chans = chans_d;
    walk_cmd.y0    = y0_d;
    walk_cmd.x0    = x0_d;
  end

  // Control FSM and output register handshake
  always_comb begin
    state_d     = state_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_comp) begin
          state_d = work ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (!walk_sts.busy && !mac_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_ch_q   <= 7'd64;
      filt_cnt_q <= 9'd32;
      stride_q   <= 3'd1;
      pad_q      <= 3'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ACTIVE_CHANNELS: act_ch_q   <= cfg_data_i[6:0];
        REG_FILTER_COUNT:    filt_cnt_q <= cfg_data_i;
        REG_CONV_STRIDE:     stride_q   <= cfg_data_i[2:0];
        REG_PAD_WIDTH:       pad_q      <= cfg_data_i[2:0];
        default: begin
        end
      endcase
    end
  end

  // Hold the request tags for the result beat
  always_ff @(posedge clk_i) begin
    if (accept && is_comp) begin
      req_row_q  <= in_data_i.out_row;
      req_col_q  <= in_data_i.out_col;
      req_filt_q <= in_data_i.filter_index;
      req_oor_q  <= oor_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.pixel_sum     <= req_oor_q ? '0 : mac_sum;
      out_q.result_row    <= req_row_q;
      out_q.result_col    <= req_col_q;
      out_q.result_filter <= req_filt_q;
      out_q.out_of_range  <= req_oor_q;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  mcp_walker #(
    .IMAGE_SIZE (IMAGE_SIZE),
    .WINDOW     (WINDOW),
    .IMG_AW     (IMG_AW),
    .WGT_AW     (WGT_AW)
  ) u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (walk_cmd),
    .sts_o      (walk_sts),
    .img_addr_o (img_ra),
    .wgt_addr_o (wgt_ra)
  );

  mcp_ram #(
    .DEPTH   (ImgDepth),
    .AW      (IMG_AW)
  ) u_image_store (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (img_wa),
    .wdata_i (in_data_i.load_value),
    .re_i    (walk_sts.issue),
    .raddr_i (img_ra),
    .rdata_o (img_rd)
  );

  mcp_ram #(
    .DEPTH   (WgtDepth),
    .AW      (WGT_AW)
  ) u_weight_store (
    .clk_i   (clk_i),
    .we_i    (wgt_we),
    .waddr_i (wgt_wa),
    .wdata_i (in_data_i.load_value),
    .re_i    (walk_sts.issue),
    .raddr_i (wgt_ra),
    .rdata_o (wgt_rd)
  );

  mcp_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (accept && is_comp),
    .issue_i (walk_sts.issue),
    .img_i   (img_rd),
    .wgt_i   (wgt_rd),
    .busy_o  (mac_busy),
    .sum_o   (mac_sum)
  );

`ifndef ASSERT_OFF
  // A flagged request never carries a sum
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.out_of_range || (out_data_o.pixel_sum == '0)))
    else $error("out-of-range result with non-zero sum");

  // Store reads only happen while a pixel is being computed
  a_issue_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_sts.issue |-> (state_q == ST_RUN))
    else $error("tap read issued outside compute");

  // A new result beat only comes out of the finish state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> ($past(state_q) == ST_DONE))
    else $error("result beat raised outside finish state");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the multichannel convolution pixel engine.
// Loads image words and weights, asks for pixels, checks each result beat.
// Needs mcp_pkg and the multichannel_conv2d_pixel top level only.
module testbench;
  import mcp_pkg::*;

  localparam int CHAN_MAX      = 64;
  localparam int IMG_SIDE      = 32;
  localparam int WIN           = 5;
  localparam int FILTER_MAX    = 256;
  localparam int PIX           = IMG_SIDE * IMG_SIDE;
  localparam int TAPS          = WIN * WIN;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 200;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  mcp_in_t               in_data   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_stall;
  logic                  out_valid;
  mcp_out_t              out_data;

  // Local copy of the engine registers
  logic [6:0] cfg_chans   = 7'd64;
  logic [8:0] cfg_filters = 9'd32;
  logic [2:0] cfg_stride  = 3'd1;
  logic [2:0] cfg_pad     = 3'd2;

  // Local copy of both stores, and which entries the stimulus has loaded
  bit [15:0] image_mem  [CHAN_MAX*PIX];
  bit [15:0] weight_mem [CHAN_MAX*TAPS];
  bit        image_set  [CHAN_MAX*PIX];
  bit        weight_set [CHAN_MAX*TAPS];

  mcp_in_t  beat_q[$];
  mcp_out_t pixel_due[$];

  int       send_idle = 6;
  int       recv_idle = 88;
  int       fault_cnt = 0;
  int       cycle_cnt = 0;
  bit       in_fire   = 1'b0;
  mcp_out_t got;
  mcp_out_t want;

  multichannel_conv2d_pixel #(
    .CHANNELS  (CHAN_MAX),
    .IMAGE_SIZE(IMG_SIDE),
    .WINDOW    (WIN),
    .FILTERS   (FILTER_MAX)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int live_channels();
    return (cfg_chans > CHAN_MAX) ? CHAN_MAX : int'(cfg_chans);
  endfunction

  function automatic int live_filters();
    return (cfg_filters > FILTER_MAX) ? FILTER_MAX : int'(cfg_filters);
  endfunction

  // Expected result of one compute beat under the current registers
  function automatic mcp_out_t conv_pixel(mcp_in_t b);
    mcp_out_t  r;
    bit [15:0] acc;
    int        y0, x0, yy, xx;
    r.result_row    = b.out_row;
    r.result_col    = b.out_col;
    r.result_filter = b.filter_index;
    r.out_of_range  = (int'(b.filter_index) >= live_filters());
    acc = '0;
    if (!r.out_of_range) begin
      y0 = int'(b.out_row) * int'(cfg_stride) - int'(cfg_pad);
      x0 = int'(b.out_col) * int'(cfg_stride) - int'(cfg_pad);
      for (int c = 0; c < live_channels(); c++) begin
        for (int i = 0; i < WIN; i++) begin
          for (int j = 0; j < WIN; j++) begin
            yy = y0 + i;
            xx = x0 + j;
            // taps in the zero border add nothing; products keep their low 16 bits
            if (yy >= 0 && yy < IMG_SIDE && xx >= 0 && xx < IMG_SIDE) begin
              acc = acc + image_mem[c*PIX + yy*IMG_SIDE + xx] * weight_mem[c*TAPS + i*WIN + j];
            end
          end
        end
      end
    end
    r.pixel_sum = acc;
    return r;
  endfunction

  function automatic mcp_in_t random_beat(logic [1:0] op);
    logic [63:0] r;
    mcp_in_t     b;
    r = {$urandom, $urandom};
    b = r[$bits(mcp_in_t)-1:0];
    b.opcode = op;
    return b;
  endfunction

  function automatic void queue_image(int ch, int pos, logic [15:0] val);
    mcp_in_t b;
    b = random_beat(OP_LOAD_IMAGE);
    b.load_channel  = 6'(ch);
    b.load_position = 10'(pos);
    b.load_value    = val;
    beat_q.push_back(b);
    image_set[ch*PIX + pos] = 1'b1;
  endfunction

  function automatic void queue_weight(int ch, int tap, logic [15:0] val);
    mcp_in_t b;
    b = random_beat(OP_LOAD_WEIGHT);
    b.load_channel  = 6'(ch);
    b.load_position = 10'(tap);
    b.load_value    = val;
    beat_q.push_back(b);
    if (tap < TAPS) begin
      weight_set[ch*TAPS + tap] = 1'b1;
    end
  endfunction

  function automatic void queue_pixel(int row, int col, int filt);
    mcp_in_t b;
    b = random_beat(OP_COMPUTE);
    b.out_row      = 5'(row);
    b.out_col      = 5'(col);
    b.filter_index = 8'(filt);
    beat_q.push_back(b);
  endfunction

  // Count the store entries a pixel would read before they are loaded;
  // with fill set, queue loads of random words for each of them
  function automatic int cover_window(int row, int col, int filt, bit fill);
    int y0, x0, yy, xx, missing;
    missing = 0;
    if (filt >= live_filters()) begin
      return 0;
    end
    y0 = row * int'(cfg_stride) - int'(cfg_pad);
    x0 = col * int'(cfg_stride) - int'(cfg_pad);
    for (int c = 0; c < live_channels(); c++) begin
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN; j++) begin
          yy = y0 + i;
          xx = x0 + j;
          if (yy >= 0 && yy < IMG_SIDE && xx >= 0 && xx < IMG_SIDE) begin
            if (!image_set[c*PIX + yy*IMG_SIDE + xx]) begin
              missing++;
              if (fill) queue_image(c, yy*IMG_SIDE + xx, 16'($urandom));
            end
            if (!weight_set[c*TAPS + i*WIN + j]) begin
              missing++;
              if (fill) queue_weight(c, i*WIN + j, 16'($urandom));
            end
          end
        end
      end
    end
    return missing;
  endfunction

  // Pick a pixel whose missing words fit the budget, else the cheapest tried;
  // queue its loads and the request, and return the beats queued
  function automatic int plan_pixel(int budget);
    int row, col, filt, cost, best_row, best_col, best_cost;
    filt      = $urandom_range(0, 255);
    best_row  = 0;
    best_col  = 0;
    best_cost = -1;
    for (int k = 0; k < 7; k++) begin
      if (k == 6) begin
        row = 0;
        col = 0;
      end else if ($urandom_range(0, 1)) begin
        row = $urandom_range(0, 4);
        col = $urandom_range(0, 4);
      end else begin
        row = $urandom_range(0, 31);
        col = $urandom_range(0, 31);
      end
      cost = cover_window(row, col, filt, 1'b0);
      if (cost <= budget || best_cost < 0 || cost < best_cost) begin
        best_row  = row;
        best_col  = col;
        best_cost = cost;
      end
      if (cost <= budget) break;
    end
    void'(cover_window(best_row, best_col, filt, 1'b1));
    queue_pixel(best_row, best_col, filt);
    return best_cost + 1;
  endfunction

  // Stray beats: loads anywhere, taps past the window, the unused opcode
  function automatic int add_noise();
    int ch, pos, kind;
    ch   = $urandom_range(0, CHAN_MAX-1);
    pos  = $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 2*TAPS);
    kind = $urandom_range(0, 2);
    if (kind == 0) begin
      queue_image(ch, pos, 16'($urandom));
      return 1;
    end
    if (kind == 1) begin
      queue_weight(ch, pos, 16'($urandom));
      return (pos < TAPS) ? 1 : 0;
    end
    beat_q.push_back(random_beat(OP_UNUSED));
    return 0;
  endfunction

  task automatic write_reg(mcp_reg_e idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    case (idx)
      REG_ACTIVE_CHANNELS: cfg_chans   = 7'(val);
      REG_FILTER_COUNT:    cfg_filters = 9'(val);
      REG_CONV_STRIDE:     cfg_stride  = 3'(val);
      REG_PAD_WIDTH:       cfg_pad     = 3'(val);
      default: ;
    endcase
  endtask

  task automatic set_config(int chans, int filters, int stride, int pad);
    write_reg(REG_ACTIVE_CHANNELS, chans);
    write_reg(REG_FILTER_COUNT, filters);
    write_reg(REG_CONV_STRIDE, stride);
    write_reg(REG_PAD_WIDTH, pad);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every beat is sent and every pixel has come back, then let the engine go quiet
  task automatic settle();
    while (beat_q.size() != 0 || in_valid || pixel_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int chans, int filters, int stride, int pad, int beats, int budget);
    int counted;
    set_config(chans, filters, stride, pad);
    counted = 0;
    while (counted < beats) begin
      if ($urandom_range(0, 99) < 15) begin
        counted += add_noise();
      end else begin
        counted += plan_pixel(budget);
      end
    end
    settle();
  endtask

  // Driver: present the next beat once the last one is taken, with random gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          in_data  <= beat_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  // Monitor: track accepted beats in the local model and check result beats
  always @(posedge clk) begin
    if (rst_n) begin
      in_fire = in_valid && !in_stall;
      if (in_fire) begin
        case (in_data.opcode)
          OP_LOAD_IMAGE: begin
            image_mem[in_data.load_channel*PIX + in_data.load_position] = in_data.load_value;
          end
          OP_LOAD_WEIGHT: begin
            if (in_data.load_position < TAPS) begin
              weight_mem[in_data.load_channel*TAPS + in_data.load_position] = in_data.load_value;
            end
          end
          OP_COMPUTE: begin
            pixel_due.push_back(conv_pixel(in_data));
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (pixel_due.size() == 0) begin
          $error("result beat with no pixel pending: row %0d col %0d filter %0d",
                 got.result_row, got.result_col, got.result_filter);
          fault_cnt++;
        end else begin
          want = pixel_due.pop_front();
          if (got.pixel_sum !== want.pixel_sum) begin
            $error("pixel_sum: expected %0d, got %0d", want.pixel_sum, got.pixel_sum);
            fault_cnt++;
          end
          if (got.result_row !== want.result_row) begin
            $error("result_row: expected %0d, got %0d", want.result_row, got.result_row);
            fault_cnt++;
          end
          if (got.result_col !== want.result_col) begin
            $error("result_col: expected %0d, got %0d", want.result_col, got.result_col);
            fault_cnt++;
          end
          if (got.result_filter !== want.result_filter) begin
            $error("result_filter: expected %0d, got %0d", want.result_filter, got.result_filter);
            fault_cnt++;
          end
          if (got.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0d, got %0d", want.out_of_range, got.out_of_range);
            fault_cnt++;
          end
        end
      end
    end else begin
      in_fire = 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    mcp_in_t beat;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset registers: extreme loads, ignored taps, unused opcode, flagged filters
    queue_image(0, 0, 16'h7fff);
    queue_image(CHAN_MAX-1, PIX-1, 16'h8000);
    queue_weight(CHAN_MAX-1, TAPS-1, 16'hffff);
    queue_weight(0, TAPS, 16'h1234);
    queue_weight(CHAN_MAX-1, 1023, 16'h0000);
    beat = '1;
    beat_q.push_back(beat);
    queue_pixel(31, 31, 32);
    queue_pixel(0, 0, 255);
    settle();

    // Zero stride, wide border: every window reads only pixel 0 against the last tap
    set_config(1, 1, 0, 4);
    queue_weight(0, TAPS-1, 16'h8000);
    queue_image(0, 0, 16'h8000);
    queue_pixel(0, 0, 0);
    queue_pixel(31, 31, 1);
    queue_weight(0, TAPS-1, 16'h7fff);
    queue_pixel(17, 5, 0);
    queue_image(0, 0, 16'h7fff);
    queue_pixel(9, 30, 0);
    queue_image(0, 0, 16'hffff);
    queue_weight(0, TAPS-1, 16'hffff);
    queue_pixel(2, 2, 0);
    settle();

    // No channels summed, filter count above the maximum, then a count of zero
    set_config(0, 511, 7, 7);
    queue_pixel(31, 31, 255);
    queue_pixel(0, 0, 0);
    settle();
    set_config(0, 0, 7, 7);
    queue_pixel(3, 4, 0);
    settle();

    // Random phases: sender mostly busy, receiver mostly stalled
    run_phase(2, 200, 1, 2, 45, 40);
    run_phase(127, 511, 0, 4, 150, 0);

    // Sender mostly idle, receiver mostly ready
    send_idle = 88;
    recv_idle = 6;
    run_phase(3, 100, 4, 0, 45, 80);
    run_phase(1, 256, 2, 1, 45, 30);

    // No gaps on either side
    send_idle = 0;
    recv_idle = 0;
    run_phase(64, 256, 4, 4, 30, 0);
    run_phase(4, 255, 1, 3, 40, 40);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
